// ===== hw/rtl/m3inv_pkg.sv =====
// m3inv_pkg: shared types and constants for the 3x3 matrix inverter
// holds the transaction structs and the cofactor product index tables
// used by matrix3_inverse; no dependencies
`default_nettype none

package m3inv_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_ELEM   = 9;
	localparam int NUM_PROD   = 18;

	// cofactor i is product 2i minus product 2i+1, adjugate sign already folded in
	localparam int MUL_A [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int MUL_B [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] inv00;
		logic signed [DATA_WIDTH-1:0] inv01;
		logic signed [DATA_WIDTH-1:0] inv02;
		logic signed [DATA_WIDTH-1:0] inv10;
		logic signed [DATA_WIDTH-1:0] inv11;
		logic signed [DATA_WIDTH-1:0] inv12;
		logic signed [DATA_WIDTH-1:0] inv20;
		logic signed [DATA_WIDTH-1:0] inv21;
		logic signed [DATA_WIDTH-1:0] inv22;
		logic                         singular;
		logic                         saturated;
	} out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/matrix3_inverse.sv =====
// matrix3_inverse: pipelined inverse of a 3x3 signed fixed-point matrix
// adjugate over exact determinant, one quotient bit per stage
// depends on m3inv_pkg
//
// usage
// - input channel in_valid / in_stall / in_data carries one matrix per transaction,
//   nine signed elements with FRAC_BITS fraction bits
// - output channel out_valid / out_stall / out_data carries the inverse, a singular
//   flag (zero determinant, all elements zero) and a saturated flag (clipped, nonsingular)
// - from acceptance to out_valid, five stages form products, cofactors, determinant
//   partials, determinant and operand magnitudes, then DATA_WIDTH stages of restoring
//   division run the nine quotients side by side, one quotient bit each, then the clamp
//   lands in the output register
// - throughput is one matrix per cycle while the receiver takes results
// - when the receiver stalls a waiting result, the whole pipeline holds and in_stall
//   is raised; nothing is dropped or repeated, and it resumes the cycle stall drops
// - reset clears all valid bits; the data registers are not reset
// - quotients truncate toward zero and clip to the signed DATA_WIDTH range
`default_nettype none

module matrix3_inverse #(
	parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  m3inv_pkg::in_t   in_data,
	output logic             out_valid,
	input  wire              out_stall,
	output m3inv_pkg::out_t  out_data
);

	localparam int W  = m3inv_pkg::DATA_WIDTH;
	localparam int NE = m3inv_pkg::NUM_ELEM;
	localparam int NP = m3inv_pkg::NUM_PROD;
	localparam int PW = 2 * W;                 // element product
	localparam int CW = 2 * W + 1;             // cofactor
	localparam int DW = 3 * W + 3;             // determinant
	localparam int NW = CW + 2 * FRAC_BITS;    // aligned numerator magnitude
	localparam int XW = (NW > DW + W + 1) ? NW : DW + W + 1;

	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [XW-1:0] rem;
		logic [W-1:0]  quo;
		logic          neg;
		logic          ovf;
	} lane_t;

	// global advance: the whole pipe moves unless a finished result is held
	logic adv;
	assign in_stall = out_valid & out_stall;
	assign adv      = ~in_stall;

	// unpack the matrix
	logic signed [W-1:0] elem [NE];
	always_comb begin
		elem[0] = in_data.m00;
		elem[1] = in_data.m01;
		elem[2] = in_data.m02;
		elem[3] = in_data.m10;
		elem[4] = in_data.m11;
		elem[5] = in_data.m12;
		elem[6] = in_data.m20;
		elem[7] = in_data.m21;
		elem[8] = in_data.m22;
	end

	// stage 1: the eighteen 2x2 minor products, plus row 0 kept for the expansion
	logic signed [PW-1:0] prod_s1 [NP];
	logic signed [W-1:0]  row_s1 [3];
	// stage 2: cofactors with adjugate signs
	logic signed [CW-1:0] adj_s2 [NE];
	logic signed [W-1:0]  row_s2 [3];
	// stage 3: determinant partial products, cofactor split in low and high halves
	logic signed [CW-1:0] adj_s3 [NE];
	logic signed [CW-1:0] plo_s3 [3];
	logic signed [CW-1:0] phi_s3 [3];
	// stage 4: determinant
	logic signed [CW-1:0] adj_s4 [NE];
	logic signed [DW-1:0] det_s4;
	// stage 5: magnitudes, signs, early overflow check
	lane_t                lane_s5 [NE];
	logic [DW-1:0]        dmag_s5;
	logic                 sing_s5;
	// division stages
	lane_t                dv_lane_s6 [W][NE];
	logic [DW-1:0]        dv_dmag_s6 [W];
	logic                 dv_sing_s6 [W];
	logic                 dv_v_s6 [W];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 3 operand split
	logic signed [CW-1:0] ext_row [3];
	logic signed [CW-1:0] ext_lo [3];
	logic signed [CW-1:0] ext_hi [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ext_row[j] = CW'(row_s2[j]);
			ext_lo[j]  = $signed({{(W+1){1'b0}}, adj_s2[3*j][W-1:0]});
			ext_hi[j]  = CW'($signed(adj_s2[3*j][CW-1:W]));
		end
	end

	// stage 4 sum
	logic signed [DW-1:0] det_c;
	always_comb begin
		det_c = '0;
		for (int j = 0; j < 3; j++) begin
			det_c = det_c + (DW'(phi_s3[j]) <<< W) + DW'(plo_s3[j]);
		end
	end

	// stage 5 magnitudes
	logic [CW-1:0] amag [NE];
	logic [DW-1:0] dmag_c;
	lane_t         lane_c [NE];
	always_comb begin
		dmag_c = det_s4[DW-1] ? (~det_s4 + 1'b1) : det_s4;
		for (int l = 0; l < NE; l++) begin
			amag[l]       = adj_s4[l][CW-1] ? (~adj_s4[l] + 1'b1) : adj_s4[l];
			lane_c[l].rem = XW'(amag[l]) << (2 * FRAC_BITS);
			lane_c[l].quo = '0;
			lane_c[l].neg = adj_s4[l][CW-1] ^ det_s4[DW-1];
			// quotient of 2^W or more always clips
			lane_c[l].ovf = lane_c[l].rem >= (XW'(dmag_c) << W);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NP; p++) begin
				prod_s1[p] <= elem[m3inv_pkg::MUL_A[p]] * elem[m3inv_pkg::MUL_B[p]];
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= elem[j];
				row_s2[j] <= row_s1[j];
				plo_s3[j] <= ext_row[j] * ext_lo[j];
				phi_s3[j] <= ext_row[j] * ext_hi[j];
			end
			for (int l = 0; l < NE; l++) begin
				adj_s2[l] <= CW'(prod_s1[2*l]) - CW'(prod_s1[2*l+1]);
				adj_s3[l] <= adj_s2[l];
				adj_s4[l] <= adj_s3[l];
			end
			det_s4  <= det_c;
			lane_s5 <= lane_c;
			dmag_s5 <= dmag_c;
			sing_s5 <= (det_s4 == '0);
		end
	end

	// restoring division, stage i resolves quotient bit W-1-i on all nine lanes
	for (genvar i = 0; i < W; i++) begin : g_div
		localparam int K = W - 1 - i;
		lane_t         src [NE];
		lane_t         nx [NE];
		logic [DW-1:0] src_dm;
		logic          src_sing;
		logic          src_v;
		logic [XW-1:0] dsh;

		if (i == 0) begin : g_head
			always_comb begin
				src      = lane_s5;
				src_dm   = dmag_s5;
				src_sing = sing_s5;
				src_v    = v_s5;
			end
		end else begin : g_body
			always_comb begin
				src      = dv_lane_s6[i-1];
				src_dm   = dv_dmag_s6[i-1];
				src_sing = dv_sing_s6[i-1];
				src_v    = dv_v_s6[i-1];
			end
		end

		always_comb begin
			dsh = XW'(src_dm) << K;
			for (int l = 0; l < NE; l++) begin
				nx[l] = src[l];
				if (src[l].rem >= dsh) begin
					nx[l].rem    = src[l].rem - dsh;
					nx[l].quo[K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s6[i] <= 1'b0;
			end else if (adv) begin
				dv_v_s6[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_lane_s6[i] <= nx;
				dv_dmag_s6[i] <= src_dm;
				dv_sing_s6[i] <= src_sing;
			end
		end
	end

	// clamp, restore sign, zero on singular
	logic [W-1:0] lim [NE];
	logic [W-1:0] qc [NE];
	logic [W-1:0] res [NE];
	logic         sat_c;
	logic         sing_c;
	m3inv_pkg::out_t out_c;
	always_comb begin
		sing_c = dv_sing_s6[W-1];
		sat_c  = 1'b0;
		for (int l = 0; l < NE; l++) begin
			lim[l] = dv_lane_s6[W-1][l].neg ? MAX_NEG : MAX_POS;
			qc[l]  = dv_lane_s6[W-1][l].quo;
			if (dv_lane_s6[W-1][l].ovf || (dv_lane_s6[W-1][l].quo > lim[l])) begin
				qc[l] = lim[l];
				sat_c = 1'b1;
			end
			res[l] = dv_lane_s6[W-1][l].neg ? (~qc[l] + 1'b1) : qc[l];
			if (sing_c) begin
				res[l] = '0;
			end
		end
		out_c.inv00     = res[0];
		out_c.inv01     = res[1];
		out_c.inv02     = res[2];
		out_c.inv10     = res[3];
		out_c.inv11     = res[4];
		out_c.inv12     = res[5];
		out_c.inv20     = res[6];
		out_c.inv21     = res[7];
		out_c.inv22     = res[8];
		out_c.singular  = sing_c;
		out_c.saturated = sat_c & ~sing_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_v_s6[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= out_c;
		end
	end

	// a singular result carries an all-zero inverse and no clip flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			!out_data.saturated && out_data.inv00 == '0 && out_data.inv01 == '0 &&
			out_data.inv02 == '0 && out_data.inv10 == '0 && out_data.inv11 == '0 &&
			out_data.inv12 == '0 && out_data.inv20 == '0 && out_data.inv21 == '0 &&
			out_data.inv22 == '0)
		else $error("singular result with nonzero inverse");

	// a clipped result has at least one element at a range limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.inv00 == MAX_POS || out_data.inv00 == MAX_NEG ||
			out_data.inv01 == MAX_POS || out_data.inv01 == MAX_NEG ||
			out_data.inv02 == MAX_POS || out_data.inv02 == MAX_NEG ||
			out_data.inv10 == MAX_POS || out_data.inv10 == MAX_NEG ||
			out_data.inv11 == MAX_POS || out_data.inv11 == MAX_NEG ||
			out_data.inv12 == MAX_POS || out_data.inv12 == MAX_NEG ||
			out_data.inv20 == MAX_POS || out_data.inv20 == MAX_NEG ||
			out_data.inv21 == MAX_POS || out_data.inv21 == MAX_NEG ||
			out_data.inv22 == MAX_POS || out_data.inv22 == MAX_NEG)
		else $error("saturated flag without a clipped element");

	// a zero determinant moving on marks the transaction singular
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && adv && det_s4 == '0 |=> v_s5 && sing_s5)
		else $error("zero determinant not flagged");

	// a held pipe keeps the stage 5 transaction in place
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !adv |=> v_s5 && $stable(dmag_s5) && $stable(sing_s5))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire
